// ----- rtl/core/stids_pkg.sv -----
// Package for the sorted table unit: item and result structs, operation,
// status and state codes. No dependencies.
package stids_pkg;

	localparam int VAL_IN_W = 32;
	localparam int POS_W    = 7;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_DELETE = 2'd1,
		FN_SEARCH = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL
	} state_t;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		func_t                      func;
		logic signed [VAL_IN_W-1:0] value;
	} in_t;

	typedef struct packed {
		status_t status;
		pos_t    position;
		pos_t    entry_count;
	} out_t;

endpackage

// ----- rtl/core/stids_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module stids_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/core/sorted_table_insert_delete_search_unit.sv -----
// Sorted table unit: ascending table of signed values with insert, delete
// and search. Depends on stids_pkg and stids_ram.
//
// Usage. An item (req: func, value) is taken at a clock edge where start is
// high and busy is low. Exactly one result (rsp: status, position,
// entry_count) follows, shown for a single cycle with done high; the
// receiver cannot stall it and must take it in that cycle.
// Insert puts the value after any equal values, delete removes the first
// equal value and closes the gap, search reports the first equal position.
// Positions are 1-based, 0 when there is none.
// An item that touches the table gives its result after a pass that reads
// each value stored before the item, then ST_TAIL; an insert into an empty
// table has nothing to read. A refused item (insert when full, delete or
// search when empty, the unused code) answers in the next cycle. busy drops
// in the cycle the result is shown, so the next item may be taken then. The
// unit takes no new item while one is in progress: busy stays high for the
// single pass over the table memory, which reads one entry and writes back
// at most one entry a cycle.
// Reset clears the count to zero; table contents are left as they are.
module sorted_table_insert_delete_search_unit
	import stids_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  req,
	output logic done,
	output out_t rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t                 state_q, state_d;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          rd_idx_q;
	logic                   vld_s1;
	logic [AW-1:0]          idx_s1;
	logic                   hit_q;
	logic                   done_q;
	out_t                   rsp_q;
	func_t                  func_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [VALUE_WIDTH-1:0] carry_q;
	logic [CW-1:0]          at_q;

	logic                   accept;
	logic                   go_scan;
	logic                   early_resp;
	logic                   issue_en;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   s1_hit;
	logic [CW-1:0]          tail_at;
	out_t                   tail_rsp;
	status_t                early_status;

	stids_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (issue_en),
		.rd_addr(rd_idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	assign accept = start && !busy;

	// Items that never touch the table are answered straight away
	always_comb begin
		go_scan      = 1'b1;
		early_status = STAT_DONE;
		priority if (req.func == FN_NOP) begin
			go_scan = 1'b0;
		end else if (req.func == FN_INSERT && count_q == CW'(TABLE_DEPTH)) begin
			go_scan      = 1'b0;
			early_status = STAT_FULL;
		end else if (req.func != FN_INSERT && count_q == '0) begin
			go_scan      = 1'b0;
			early_status = STAT_EMPTY;
		end else begin
			go_scan = 1'b1;
		end
	end

	assign early_resp = accept && !go_scan;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && go_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!vld_s1 && rd_idx_q == count_q) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		busy     = (state_q != ST_IDLE);
		issue_en = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	end

	assign tail_at = hit_q ? at_q : count_q;

	// Stage 1: entry data back from the table; decide and write back.
	// Insert carries each displaced entry one place up; delete moves each
	// later entry one place down.
	always_comb begin
		s1_hit  = 1'b0;
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data;
		if (state_q == ST_TAIL && func_q == FN_INSERT) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_data = hit_q ? carry_q : key_q;
		end else if (vld_s1) begin
			unique case (func_q)
				FN_INSERT: begin
					if (!hit_q && $signed(key_q) < $signed(rd_data)) begin
						s1_hit  = 1'b1;
						wr_en   = 1'b1;
						wr_data = key_q;
					end else if (hit_q) begin
						wr_en   = 1'b1;
						wr_data = carry_q;
					end
				end
				FN_DELETE: begin
					if (!hit_q && rd_data == key_q) begin
						s1_hit = 1'b1;
					end else if (hit_q) begin
						wr_en   = 1'b1;
						wr_addr = idx_s1 - AW'(1);
					end
				end
				FN_SEARCH: begin
					s1_hit = !hit_q && rd_data == key_q;
				end
				default: begin
					s1_hit = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		tail_rsp.status      = STAT_DONE;
		tail_rsp.position    = pos_t'(tail_at + CW'(1));
		tail_rsp.entry_count = pos_t'(count_q);
		unique case (func_q)
			FN_INSERT: begin
				tail_rsp.entry_count = pos_t'(count_q + CW'(1));
			end
			FN_DELETE: begin
				if (hit_q) begin
					tail_rsp.entry_count = pos_t'(count_q - CW'(1));
				end else begin
					tail_rsp.status   = STAT_NOT_FOUND;
					tail_rsp.position = '0;
				end
			end
			FN_SEARCH: begin
				if (!hit_q) begin
					tail_rsp.status   = STAT_NOT_FOUND;
					tail_rsp.position = '0;
				end
			end
			default: begin
				tail_rsp.position = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			hit_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue_en;
			done_q  <= early_resp || (state_q == ST_TAIL);
			if (accept) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
			end else begin
				if (issue_en) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (s1_hit) begin
					hit_q <= 1'b1;
				end
			end
			if (state_q == ST_TAIL) begin
				if (func_q == FN_INSERT) begin
					count_q <= count_q + CW'(1);
				end else if (func_q == FN_DELETE && hit_q) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			key_q  <= VALUE_WIDTH'(req.value);
		end
		if (issue_en) begin
			idx_s1 <= rd_idx_q[AW-1:0];
		end
		if (s1_hit) begin
			at_q <= CW'(idx_s1);
		end
		if (vld_s1) begin
			carry_q <= rd_data;
		end
		if (early_resp) begin
			rsp_q.status      <= early_status;
			rsp_q.position    <= '0;
			rsp_q.entry_count <= pos_t'(count_q);
		end else if (state_q == ST_TAIL) begin
			rsp_q <= tail_rsp;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_TAIL || early_resp))
		else $error("result strobe without a finished item");

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q == ST_SCAN)
		else $error("table read data outside the scan");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL && func_q == FN_INSERT) |=>
			count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the table");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> rd_idx_q <= count_q)
		else $error("read index ran past the entry count");

endmodule

// ----- tb/sv/sorted_table_insert_delete_search_unit_tb.sv -----
// Self-checking testbench for the sorted table unit: a shadow table predicts
// each result and a monitor compares every strobed result against it.
// Depends on stids_pkg and the sorted_table_insert_delete_search_unit RTL.
module sorted_table_insert_delete_search_unit_tb;
	import stids_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;

	typedef struct {
		in_t item;
		bit  drain_first;
	} pend_t;

	typedef enum {
		MIX_GROW,
		MIX_SHRINK,
		MIX_EVEN
	} mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	in_t  req = '0;
	logic busy;
	logic done;
	out_t rsp;

	pend_t pending_ops[$];
	out_t  expected_rsp[$];
	int    fail_count = 0;

	// shadow of the block's table, updated as items are accepted
	logic signed [31:0] shadow_table[DEPTH];
	int                 shadow_count = 0;

	// multiset of values the stimulus believes are stored
	logic signed [31:0] gen_pool[$];

	int gap_left = 0;
	int burst_left = 0;

	sorted_table_insert_delete_search_unit #(
		.TABLE_DEPTH(DEPTH),
		.VALUE_WIDTH(32)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic out_t apply_table_op(in_t it);
		out_t               r;
		int                 at;
		logic signed [31:0] v;
		v = it.value;
		r.status = STAT_DONE;
		r.position = '0;
		case (it.func)
			FN_INSERT: begin
				if (shadow_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					// after any equal values, so duplicates keep arrival order
					at = shadow_count;
					for (int i = shadow_count - 1; i >= 0; i--)
						if (shadow_table[i] > v)
							at = i;
					for (int i = shadow_count; i > at; i--)
						shadow_table[i] = shadow_table[i-1];
					shadow_table[at] = v;
					shadow_count++;
					r.position = pos_t'(at + 1);
				end
			end
			FN_DELETE, FN_SEARCH: begin
				if (shadow_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					at = shadow_count;
					for (int i = shadow_count - 1; i >= 0; i--)
						if (shadow_table[i] == v)
							at = i;
					if (at == shadow_count) begin
						r.status = STAT_NOT_FOUND;
					end else begin
						r.position = pos_t'(at + 1);
						if (it.func == FN_DELETE) begin
							for (int i = at; i + 1 < shadow_count; i++)
								shadow_table[i] = shadow_table[i+1];
							shadow_count--;
						end
					end
				end
			end
			default: ;
		endcase
		r.entry_count = pos_t'(shadow_count);
		return r;
	endfunction

	function automatic void queue_op(func_t f, logic signed [31:0] v, bit drain_first);
		pend_t p;
		int    hit;
		p.item.func = f;
		p.item.value = v;
		p.drain_first = drain_first;
		pending_ops.push_back(p);
		hit = -1;
		if (f == FN_INSERT && gen_pool.size() < DEPTH)
			gen_pool.push_back(v);
		if (f == FN_DELETE) begin
			for (int i = gen_pool.size() - 1; i >= 0; i--)
				if (gen_pool[i] == v)
					hit = i;
			if (hit >= 0)
				gen_pool.delete(hit);
		end
	endfunction

	function automatic logic [31:0] any_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 15) - 8;
			6, 7: return $urandom();
			8: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: begin
				if (gen_pool.size() != 0)
					return gen_pool[$urandom_range(0, gen_pool.size() - 1)];
				return $urandom_range(0, 15) - 8;
			end
		endcase
	endfunction

	// driver: bursts of items with random gaps; a flagged item waits for an empty pipe
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			if (start && !busy)
				expected_rsp.push_back(apply_table_op(req));
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_ops.size() != 0 &&
						!(pending_ops[0].drain_first && expected_rsp.size() != 0)) begin
					start <= 1'b1;
					req <= pending_ops[0].item;
					void'(pending_ops.pop_front());
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
					end
					burst_left--;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: results cannot be held off, so every done cycle is checked
	always @(posedge clk) begin : rsp_check
		out_t want;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected result status %0d position %0d count %0d",
					$time, rsp.status, rsp.position, rsp.entry_count);
				fail_count++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d got %0d",
						$time, want.status, rsp.status);
					fail_count++;
				end
				if (rsp.position !== want.position) begin
					$display("%0t: position expected %0d got %0d",
						$time, want.position, rsp.position);
					fail_count++;
				end
				if (rsp.entry_count !== want.entry_count) begin
					$display("%0t: entry_count expected %0d got %0d",
						$time, want.entry_count, rsp.entry_count);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		mix_t               mode;
		int                 seg_left;
		int                 r;
		func_t              f;
		logic signed [31:0] v;

		// empty table, extremes, duplicates, hits and misses, unused code
		queue_op(FN_SEARCH, 32'sd5, 1'b0);
		queue_op(FN_DELETE, 32'sd5, 1'b0);
		queue_op(FN_NOP, 32'sd5, 1'b0);
		queue_op(FN_INSERT, 32'sd0, 1'b0);
		queue_op(FN_INSERT, 32'sh7fff_ffff, 1'b0);
		queue_op(FN_INSERT, 32'sh8000_0000, 1'b0);
		queue_op(FN_INSERT, -32'sd1, 1'b0);
		queue_op(FN_INSERT, 32'sd0, 1'b0);
		queue_op(FN_INSERT, 32'sd0, 1'b0);
		queue_op(FN_SEARCH, 32'sd0, 1'b0);
		queue_op(FN_SEARCH, 32'sd7, 1'b0);
		queue_op(FN_DELETE, 32'sd0, 1'b0);
		queue_op(FN_NOP, -32'sd1, 1'b0);
		queue_op(FN_DELETE, 32'sd12345, 1'b0);
		queue_op(FN_SEARCH, 32'sh7fff_ffff, 1'b0);
		queue_op(FN_SEARCH, 32'sh8000_0000, 1'b0);
		queue_op(FN_DELETE, 32'sh8000_0000, 1'b0);
		queue_op(FN_DELETE, 32'sh7fff_ffff, 1'b0);
		queue_op(FN_INSERT, 32'sd1, 1'b0);
		queue_op(FN_INSERT, -32'sd2, 1'b0);
		queue_op(FN_DELETE, -32'sd1, 1'b0);
		queue_op(FN_DELETE, 32'sd0, 1'b0);
		queue_op(FN_DELETE, 32'sd0, 1'b0);
		queue_op(FN_DELETE, 32'sd1, 1'b0);
		queue_op(FN_DELETE, -32'sd2, 1'b0);

		// fill past full first, then drain past empty, then mixed segments
		mode = MIX_GROW;
		seg_left = 90;
		for (int n = 0; n < 400; n++) begin
			if (seg_left == 0) begin
				if (mode == MIX_GROW && n < 100)
					mode = MIX_SHRINK;
				else
					mode = mix_t'($urandom_range(0, 2));
				seg_left = (n < 180) ? 90 : $urandom_range(20, 60);
			end
			seg_left--;
			r = $urandom_range(0, 99);
			case (mode)
				MIX_GROW: begin
					if (r < 85) f = FN_INSERT;
					else if (r < 90) f = FN_SEARCH;
					else if (r < 95) f = FN_DELETE;
					else f = FN_NOP;
				end
				MIX_SHRINK: begin
					if (r < 70) f = FN_DELETE;
					else if (r < 85) f = FN_SEARCH;
					else if (r < 95) f = FN_INSERT;
					else f = FN_NOP;
				end
				default: begin
					if (r < 40) f = FN_INSERT;
					else if (r < 70) f = FN_DELETE;
					else if (r < 95) f = FN_SEARCH;
					else f = FN_NOP;
				end
			endcase
			if (f != FN_INSERT && gen_pool.size() != 0 && $urandom_range(0, 3) != 0)
				v = gen_pool[$urandom_range(0, gen_pool.size() - 1)];
			else
				v = any_value();
			queue_op(f, v, n == 0 || $urandom_range(0, 49) == 0);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || start)
			@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 16) @(posedge clk);

		if (fail_count == 0)
			$display("sorted_table_insert_delete_search_unit: match");
		else
			$display("sorted_table_insert_delete_search_unit: mismatch");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("sorted_table_insert_delete_search_unit: mismatch");
		$finish;
	end

endmodule
